@@ rtl/core/key_set_sorter_top_assert.svh @@
// ---------------------------------------------------------------------------
// key_set_sorter_top_assert.svh
// Assertion macros shared by the sorter's checker.
// ---------------------------------------------------------------------------
`ifndef KEY_SET_SORTER_TOP_ASSERT_SVH
`define KEY_SET_SORTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define KSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define KSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/kss_pkg.sv @@
// ---------------------------------------------------------------------------
// kss_pkg
// Shared constants, control codes and types of the key set sorter.
// ---------------------------------------------------------------------------
package kss_pkg;

  // Default sizing
  localparam int MAX_KEYS_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_KEYS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING  = 1'd1;

  // Cell operations, broadcast to the whole row
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;  // shift towards the tail, key enters cell 0
  localparam logic [1:0] OP_SORT  = 2'd2;  // compare-exchange with the pair partner
  localparam logic [1:0] OP_DRAIN = 2'd3;  // shift towards the head, cell 0 leaves

  typedef struct packed {
    logic [1:0] op;
    logic       phase;  // pairing parity of the current sort pass
  } kss_ctrl_t;

  typedef struct packed {
    logic signed_keys;
    logic descending;
  } kss_cfg_t;

  typedef struct packed {
    logic head_vld;
    logic next_vld;
  } kss_stat_t;

endpackage

@@ rtl/core/key_set_sorter_top.sv @@
// ---------------------------------------------------------------------------
// key_set_sorter_top
// Collects a set of keys into a row of cells, sorts it by odd-even
// transposition passes and streams it out in order.
// ---------------------------------------------------------------------------
// Channel   | Dir | Handshake          | Content
// s (keys)  | in  | s_tvalid/s_tready  | tdata key, tlast end of set
// m (keys)  | out | m_tvalid/m_tready  | tdata sorted key, tlast end, tuser overflow
// cfg       | in  | cfg_we             | cfg_idx register, cfg_wdata value
//
// Keys are taken one per cycle while collecting; a set of n held keys then
// needs n sort passes in the cell row, one compare-exchange pass per cycle.
// Results leave one per cycle from cell 0; no key is taken from the last key
// of a set until the last result of that set has been transferred.
// A stall on the output holds the whole row. Reset clears all valid bits,
// counts and registers; no clearing pass is needed.
// ---------------------------------------------------------------------------
module key_set_sorter_top #(
  parameter int MAX_KEYS  = kss_pkg::MAX_KEYS_DEF,
  parameter int KEY_WIDTH = kss_pkg::KEY_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [kss_pkg::DATA_W-1:0]     s_tdata_i,   // [31:0] key_value
  input  logic                           s_tlast_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [kss_pkg::DATA_W-1:0]     m_tdata_o,   // [31:0] sorted_key
  output logic                           m_tlast_o,
  output logic                           m_tuser_o,   // [0] overflow
  input  logic                           cfg_we_i,
  input  logic [kss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kss_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import kss_pkg::*;

  kss_ctrl_t            ctrl;
  kss_cfg_t             cfg;
  kss_stat_t            stat;
  logic [KEY_WIDTH-1:0] in_key;
  logic [KEY_WIDTH-1:0] key_w [MAX_KEYS];
  logic                 vld_w [MAX_KEYS];

  // Fit the port key to the internal key width
  generate
    if (KEY_WIDTH <= DATA_W) begin : g_narrow
      assign in_key    = s_tdata_i[KEY_WIDTH-1:0];
      assign m_tdata_o = {{(DATA_W-KEY_WIDTH){1'b0}}, key_w[0]};
    end else begin : g_wide
      assign in_key    = {{(KEY_WIDTH-DATA_W){1'b0}}, s_tdata_i};
      assign m_tdata_o = key_w[0][DATA_W-1:0];
    end
  endgenerate

  assign stat.head_vld = vld_w[0];
  assign stat.next_vld = vld_w[1];

  kss_ctrl #(
    .MAX_KEYS (MAX_KEYS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tlast_i   (s_tlast_i),
    .s_tready_o  (s_tready_o),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tlast_o   (m_tlast_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .cfg_o       (cfg)
  );

  // Row of cells, cell 0 at the head
  generate
    for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] lo_key, hi_key;
      logic                 lo_vld, hi_vld;

      if (i == 0) begin : g_head
        assign lo_key = in_key;
        assign lo_vld = 1'b1;
      end else begin : g_body_lo
        assign lo_key = key_w[i-1];
        assign lo_vld = vld_w[i-1];
      end

      if (i == MAX_KEYS - 1) begin : g_tail
        assign hi_key = '0;
        assign hi_vld = 1'b0;
      end else begin : g_body_hi
        assign hi_key = key_w[i+1];
        assign hi_vld = vld_w[i+1];
      end

      kss_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .IDX       (i)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .cfg_i    (cfg),
        .lo_key_i (lo_key),
        .lo_vld_i (lo_vld),
        .hi_key_i (hi_key),
        .hi_vld_i (hi_vld),
        .key_o    (key_w[i]),
        .vld_o    (vld_w[i])
      );
    end
  endgenerate

endmodule

@@ rtl/core/kss_cell.sv @@
// ---------------------------------------------------------------------------
// kss_cell
// One cell of the sorting row: holds one key and its valid bit, loads from
// the lower neighbour, drains from the upper one and compare-exchanges with
// its pair partner during sort passes.
// ---------------------------------------------------------------------------
module kss_cell #(
  parameter int KEY_WIDTH = kss_pkg::KEY_WIDTH_DEF,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kss_pkg::kss_ctrl_t   ctrl_i,
  input  kss_pkg::kss_cfg_t    cfg_i,
  input  logic [KEY_WIDTH-1:0] lo_key_i,
  input  logic                 lo_vld_i,
  input  logic [KEY_WIDTH-1:0] hi_key_i,
  input  logic                 hi_vld_i,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic                 vld_o
);
  import kss_pkg::*;

  localparam logic                 IDX_ODD  = ((IDX % 2) == 1);
  localparam logic                 HAS_LO   = (IDX != 0);
  localparam logic [KEY_WIDTH-1:0] SIGN_BIT = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 vld_q, vld_d;
  logic                 is_lower;
  logic [KEY_WIDTH-1:0] part_key;
  logic                 part_vld;
  logic [KEY_WIDTH-1:0] cmp_x, cmp_y;
  logic                 x_first;
  logic                 swap;

  // Pick the pair partner for this pass
  always_comb begin
    is_lower = (ctrl_i.phase == IDX_ODD);
    part_key = is_lower ? hi_key_i : lo_key_i;
    part_vld = is_lower ? hi_vld_i : (lo_vld_i & HAS_LO);
  end

  // Upper key against lower key: swap when the upper one must go first
  always_comb begin
    cmp_x   = (is_lower ? part_key : key_q) ^ (cfg_i.signed_keys ? SIGN_BIT : '0);
    cmp_y   = (is_lower ? key_q : part_key) ^ (cfg_i.signed_keys ? SIGN_BIT : '0);
    x_first = cfg_i.descending ? (cmp_x > cmp_y) : (cmp_x < cmp_y);
    swap    = vld_q & part_vld & x_first;
  end

  // Next contents of the cell
  always_comb begin
    key_d = key_q;
    vld_d = vld_q;
    case (ctrl_i.op)
      OP_LOAD: begin
        key_d = lo_key_i;
        vld_d = lo_vld_i;
      end
      OP_SORT: begin
        if (swap) begin
          key_d = part_key;
        end
      end
      OP_DRAIN: begin
        key_d = hi_key_i;
        vld_d = hi_vld_i;
      end
      default: begin
        key_d = key_q;
        vld_d = vld_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign vld_o = vld_q;

endmodule

@@ rtl/core/kss_ctrl.sv @@
// ---------------------------------------------------------------------------
// kss_ctrl
// Sequencer of the sorter: collects the set, runs the sort passes, drains
// the row, and holds the configuration registers.
// ---------------------------------------------------------------------------
module kss_ctrl #(
  parameter int MAX_KEYS = kss_pkg::MAX_KEYS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tlast_i,
  output logic                           s_tready_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic                           m_tlast_o,
  output logic                           m_tuser_o,
  input  logic                           cfg_we_i,
  input  logic [kss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kss_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  kss_pkg::kss_stat_t             stat_i,
  output kss_pkg::kss_ctrl_t             ctrl_o,
  output kss_pkg::kss_cfg_t              cfg_o
);
  import kss_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEYS + 1);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_SORT    = 2'd1;
  localparam logic [1:0] ST_DRAIN   = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pass_q, pass_d;
  logic             ovf_q, ovf_d;
  kss_cfg_t         cfg_q, cfg_d;
  logic             full;
  logic             in_hs, out_hs;

  assign full       = (count_q == CNT_W'(MAX_KEYS));
  assign s_tready_o = (state_q == ST_COLLECT);
  assign m_tvalid_o = (state_q == ST_DRAIN) & stat_i.head_vld;
  assign m_tlast_o  = ~stat_i.next_vld;
  assign m_tuser_o  = ovf_q;
  assign in_hs      = s_tvalid_i & s_tready_o;
  assign out_hs     = m_tvalid_o & m_tready_i;

  // Sequence collect, sort passes and drain
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pass_d       = pass_q;
    ovf_d        = ovf_q;
    ctrl_o.op    = OP_HOLD;
    ctrl_o.phase = pass_q[0];
    case (state_q)
      ST_COLLECT: begin
        if (in_hs) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            ctrl_o.op = OP_LOAD;
            count_d   = CNT_W'(count_q + 1'b1);
          end
          if (s_tlast_i) begin
            state_d = ST_SORT;
            pass_d  = '0;
          end
        end
      end
      ST_SORT: begin
        ctrl_o.op = OP_SORT;
        pass_d    = CNT_W'(pass_q + 1'b1);
        if (CNT_W'(pass_q + 1'b1) == count_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_hs) begin
          ctrl_o.op = OP_DRAIN;
          if (!stat_i.next_vld) begin
            state_d = ST_COLLECT;
            count_d = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  // Configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIGNED_KEYS: cfg_d.signed_keys = cfg_wdata_i[0];
        REG_DESCENDING:  cfg_d.descending  = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      count_q <= '0;
      pass_q  <= '0;
      ovf_q   <= 1'b0;
      cfg_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pass_q  <= pass_d;
      ovf_q   <= ovf_d;
      cfg_q   <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/kss_checker.sv @@
// ---------------------------------------------------------------------------
// kss_checker
// Port-level checks of the key set sorter, bound to the top level.
// ---------------------------------------------------------------------------
`include "key_set_sorter_top_assert.svh"

module kss_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_tvalid_i,
  input logic                       s_tready_o,
  input logic                       s_tlast_i,
  input logic                       m_tvalid_o,
  input logic                       m_tready_i,
  input logic [kss_pkg::DATA_W-1:0] m_tdata_o,
  input logic                       m_tlast_o
);

  // A stalled result holds its key
  `KSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o), "stalled result changed")

  // No key is taken while a sorted run is being emitted
  `KSS_ASSERT_IMP(a_no_in_while_out, clk_i, rst_ni, m_tvalid_o, !s_tready_o, "key taken during output")

  // The last key of a set closes the input
  `KSS_ASSERT_NXT(a_busy_after_last, clk_i, rst_ni, s_tvalid_i && s_tready_o && s_tlast_i, !s_tready_o, "input open after last key")

  // The run ends with its flagged result
  `KSS_ASSERT_NXT(a_run_ends, clk_i, rst_ni, m_tvalid_o && m_tready_i && m_tlast_o, !m_tvalid_o && s_tready_o, "output continued after last")

endmodule

bind key_set_sorter_top kss_checker u_kss_checker (.*);

@@ tb/key_set_sorter_checker.sv @@
// ----------------------------------------------------------------------------
// key_set_sorter_checker
// Watches the key, result and register channels of the key set sorter,
// predicts each sorted run and compares it with what the block emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module key_set_sorter_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [kss_pkg::DATA_W-1:0]     s_tdata_i,   // [31:0] key_value
  input  logic                           s_tlast_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [kss_pkg::DATA_W-1:0]     m_tdata_i,   // [31:0] sorted_key
  input  logic                           m_tlast_i,
  input  logic                           m_tuser_i,   // [0] overflow
  input  logic                           cfg_we_i,
  input  logic [kss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kss_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import kss_pkg::*;

  localparam int STORE_DEPTH = MAX_KEYS_DEF;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic              last;
    logic              ovf;
  } sorted_item_t;

  // Predicted state of the block
  logic [DATA_W-1:0] held_keys [$];
  logic              set_dropped;
  logic              cfg_signed;
  logic              cfg_desc;
  sorted_item_t      sorted_run_q [$];

  // True when key a leaves ahead of key b under the current settings
  function automatic logic precedes(input logic [DATA_W-1:0] a,
                                    input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    x = a;
    y = b;
    if (cfg_signed) begin
      x[DATA_W-1] = ~x[DATA_W-1];
      y[DATA_W-1] = ~y[DATA_W-1];
    end
    return cfg_desc ? (x > y) : (x < y);
  endfunction

  // Sort the held keys and queue them as the run the block must emit
  task automatic close_set();
    logic [DATA_W-1:0] work [STORE_DEPTH];
    logic [DATA_W-1:0] v;
    sorted_item_t      item;
    int                n;
    int                i;
    int                j;
    n = held_keys.size();
    for (i = 0; i < n; i++) work[i] = held_keys[i];
    for (i = 1; i < n; i++) begin
      v = work[i];
      j = i;
      while (j > 0 && precedes(v, work[j-1])) begin
        work[j] = work[j-1];
        j--;
      end
      work[j] = v;
    end
    for (i = 0; i < n; i++) begin
      item.key  = work[i];
      item.last = (i == n - 1);
      item.ovf  = set_dropped;
      sorted_run_q.push_back(item);
    end
    held_keys.delete();
    set_dropped = 1'b0;
  endtask

  // Compare one emitted result with the oldest prediction
  task automatic check_result();
    sorted_item_t want;
    if (sorted_run_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: unexpected result key=%h last=%b ovf=%b", $realtime,
                 m_tdata_i, m_tlast_i, m_tuser_i);
    end else begin
      want = sorted_run_q.pop_front();
      if (want.key !== m_tdata_i || want.last !== m_tlast_i || want.ovf !== m_tuser_i)
      begin
        fail_count_o++;
        if (fail_count_o <= 10)
          $display("%0t: result differs: want key=%h last=%b ovf=%b, got key=%h last=%b ovf=%b",
                   $realtime, want.key, want.last, want.ovf,
                   m_tdata_i, m_tlast_i, m_tuser_i);
      end
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    set_dropped  = 1'b0;
    cfg_signed   = 1'b0;
    cfg_desc     = 1'b0;
  end

  // Follow every transaction at the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      held_keys.delete();
      sorted_run_q.delete();
      set_dropped = 1'b0;
      cfg_signed  = 1'b0;
      cfg_desc    = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SIGNED_KEYS: cfg_signed = cfg_wdata_i[0];
          REG_DESCENDING:  cfg_desc   = cfg_wdata_i[0];
          default: ;
        endcase
      end
      // Results first, so a run closed at this edge is not matched early
      if (m_tvalid_i && m_tready_i) check_result();
      if (s_tvalid_i && s_tready_i) begin
        if (held_keys.size() < STORE_DEPTH) held_keys.push_back(s_tdata_i);
        else set_dropped = 1'b1;
        if (s_tlast_i) close_set();
      end
    end
    pending_o = sorted_run_q.size();
  end

endmodule

@@ tb/key_set_sorter_top_tb.sv @@
// ----------------------------------------------------------------------------
// key_set_sorter_top_tb
// Feeds key sets of many sizes, overfull sets among them, under every order
// and signedness setting, with random gaps on both streams; a checker
// compares every sorted run with its own prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module key_set_sorter_top_tb;
  import kss_pkg::*;

  localparam int TARGET_KEYS = 420;

  logic                  clk;
  logic                  rst_n;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [DATA_W-1:0]     m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  logic              tx_burst;
  logic              rx_burst;
  logic [DATA_W-1:0] set_keys [$];
  int                keys_sent;
  int                sets_sent;
  int                overfull_sets;
  int                settings_used;

  key_set_sorter_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tlast_i   (s_tlast),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .m_tlast_o   (m_tlast),
    .m_tuser_o   (m_tuser),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  key_set_sorter_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .m_tuser_i    (m_tuser),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("key_set_sorter_top: mismatch");
    $finish;
  end

  // Result side: random stall after each transaction, none in burst mode
  initial begin : rx_side
    int stall_left;
    m_tready   = 1'b0;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
      end
      @(posedge clk);
      if (m_tvalid && m_tready) stall_left = rx_burst ? 0 : $urandom_range(0, 6);
    end
  end

  // Write one register for a single cycle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic value);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Hold until every predicted result has been taken, then let the row settle
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Offer one key and hold it until the block takes it
  task automatic send_key(input logic [DATA_W-1:0] key, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = key;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    keys_sent++;
  endtask

  // Send the keys in set_keys as one set, the final one marked last
  task automatic send_set();
    int i;
    for (i = 0; i < set_keys.size(); i++) send_key(set_keys[i], i == set_keys.size() - 1);
    s_tvalid = 1'b0;
    if (set_keys.size() > MAX_KEYS_DEF) overfull_sets++;
    sets_sent++;
    set_keys.delete();
  endtask

  // Mostly full-range keys, with extremes and near-duplicates mixed in
  function automatic logic [DATA_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      1:       return $urandom_range(0, 3);
      2:       return 32'h8000_0000 | $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    int phase;
    int n_sets;
    int size;
    int r;
    int s;
    int i;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_SIGNED_KEYS;
    cfg_wdata     = '0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    keys_sent     = 0;
    sets_sent     = 0;
    overfull_sets = 0;
    settings_used = 1;
    rst_n         = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: single keys, extremes with ties, all-equal set (reset settings)
    set_keys = '{32'h0000_0005};
    send_set();
    set_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hA5A5_5A5A};
    send_set();
    set_keys = '{32'hFFFF_FFFF};
    send_set();
    set_keys = '{32'h1234_5678, 32'h1234_5678, 32'h1234_5678};
    send_set();
    settle();

    // Directed: signed ascending, then unsigned descending
    write_reg(REG_SIGNED_KEYS, 1'b1);
    write_reg(REG_DESCENDING, 1'b0);
    set_keys = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
    send_set();
    settle();
    write_reg(REG_SIGNED_KEYS, 1'b0);
    write_reg(REG_DESCENDING, 1'b1);
    set_keys = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
    send_set();
    settings_used += 2;

    // Random phases: cycle through all four settings first, then pick at random
    phase = 0;
    s     = 0;
    while (keys_sent < TARGET_KEYS) begin
      settle();
      write_reg(REG_SIGNED_KEYS, phase < 4 ? phase[0] : 1'($urandom_range(0, 1)));
      write_reg(REG_DESCENDING,  phase < 4 ? phase[1] : 1'($urandom_range(0, 1)));
      settings_used++;
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n_sets   = $urandom_range(2, 6);
      repeat (n_sets) begin
        // Overfull set with its last key dropped, a set that just fills the store
        if (s == 0) begin
          size = MAX_KEYS_DEF + 1;
        end else if (s == 3) begin
          size = MAX_KEYS_DEF;
        end else begin
          r = $urandom_range(0, 24);
          if (r == 0)      size = $urandom_range(MAX_KEYS_DEF + 1, MAX_KEYS_DEF + 6);
          else if (r == 1) size = $urandom_range(MAX_KEYS_DEF - 8, MAX_KEYS_DEF);
          else             size = $urandom_range(1, 12);
        end
        for (i = 0; i < size; i++) set_keys.push_back(pick_key());
        send_set();
        s++;
      end
      phase++;
    end

    // Drain and give the verdict
    settle();
    repeat (16) @(negedge clk);
    $display("Sent %0d keys in %0d sets, %0d of them over capacity,", keys_sent, sets_sent,
             overfull_sets);
    $display("across %0d register settings covering both orders and both key types.",
             settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("key_set_sorter_top: match");
    end else begin
      $display("key_set_sorter_top: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/kss_pkg.sv
rtl/core/kss_cell.sv
rtl/core/kss_ctrl.sv
rtl/core/key_set_sorter_top.sv
rtl/core/kss_checker.sv
tb/key_set_sorter_checker.sv
tb/key_set_sorter_top_tb.sv
